// File: rtl/hfr_pkg.sv
package hfr_pkg;

  // Header line limits
  localparam int unsigned HDR_LINE_MAX = 512;
  localparam int unsigned LANG_MAX     = 31;
  localparam int unsigned CNT_W        = $clog2(HDR_LINE_MAX);
  localparam int unsigned LLEN_W       = $clog2(LANG_MAX + 1);

  // FNV-1a 32
  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;

  // Special characters
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Result kinds
  localparam logic [1:0] KIND_ID      = 2'd0;
  localparam logic [1:0] KIND_CODE    = 2'd1;
  localparam logic [1:0] KIND_STDIN   = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  // Frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_HDR  = 3'd1;
  localparam logic [2:0] ST_BAD_ID   = 3'd2;
  localparam logic [2:0] ST_TOO_BIG  = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_BAD_HEX  = 3'd5;
  localparam logic [2:0] ST_LIMITS   = 3'd6;

  // Config register indexes
  localparam logic [1:0] CFG_MAX_ID    = 2'd0;
  localparam logic [1:0] CFG_MAX_HEX   = 2'd1;
  localparam logic [1:0] CFG_MAX_CODE  = 2'd2;
  localparam logic [1:0] CFG_MAX_STDIN = 2'd3;

  // Header summary handed to the body logic
  typedef struct packed {
    logic        line_end;
    logic [2:0]  status;
    logic [6:0]  id_len;
    logic [18:0] code_hex;
    logic [18:0] stdin_hex;
    logic [63:0] timeout;
    logic [31:0] checksum;
    logic        node;
  } hdr_info_t;

  // Hex digit value, 16 when not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // One FNV-1a step; prime 0x01000193 as shift-add
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// File: rtl/hfr_hdr.sv
module hfr_hdr (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                restart,
  input  logic [6:0]          max_id,
  input  logic [18:0]         max_hex,
  output hfr_pkg::hdr_info_t  info
);

  typedef enum logic [2:0] {
    PH_TAG, PH_SKIP, PH_NUM, PH_LANG, PH_HEX0, PH_HEX, PH_DONE, PH_FAIL
  } phase_t;

  typedef struct packed {
    phase_t                     phase;
    logic [hfr_pkg::CNT_W-1:0]  cnt;
    logic [2:0]                 fld;
    logic [63:0]                acc;
    logic [hfr_pkg::LLEN_W-1:0] llen;
    logic                       m_node;
    logic                       m_js;
    logic [31:0]                ck;
    logic [6:0]                 idl;
    logic [18:0]                chex;
    logic [18:0]                shex;
    logic [63:0]                tmo;
    logic                       szerr;
  } hst_t;

  localparam hst_t HST_RST = '{phase: PH_TAG, cnt: '0, fld: '0, acc: '0, llen: '0,
                               m_node: 1'b1, m_js: 1'b1, ck: '0, idl: '0,
                               chex: '0, shex: '0, tmo: '0, szerr: 1'b0};

  hst_t st_r, st_nxt;

  function automatic logic [7:0] tag_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = 8'h5A;
      2'd1:    c = 8'h42;
      2'd2:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] node_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = 8'h6E;
      2'd1:    c = 8'h6F;
      2'd2:    c = 8'h64;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] js_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h6A;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h76;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h73;
      4'd5:    c = 8'h63;
      4'd6:    c = 8'h72;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h70;
      4'd9:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Close the current field and store its value
  function automatic hst_t field_done(input hst_t si, input logic [6:0] mid,
                                      input logic [18:0] mhex);
    hst_t s;
    s = si;
    case (s.fld)
      3'd0: s.idl = (s.acc >= 64'd1 && s.acc <= {57'd0, mid}) ? s.acc[6:0] : 7'd0;
      3'd2: s.tmo = s.acc;
      3'd3: begin
        if (s.acc > {45'd0, mhex}) begin
          s.szerr = 1'b1;
          s.chex  = '0;
        end else begin
          s.chex = s.acc[18:0];
        end
      end
      3'd4: begin
        if (s.acc > {45'd0, mhex}) begin
          s.szerr = 1'b1;
          s.shex  = '0;
        end else begin
          s.shex = s.acc[18:0];
        end
      end
      3'd5: s.ck = s.acc[31:0];
      default: ;
    endcase
    s.acc   = '0;
    s.fld   = s.fld + 3'd1;
    s.phase = (s.fld > 3'd5) ? PH_DONE : PH_SKIP;
    return s;
  endfunction

  function automatic hst_t lang_char(input hst_t si, input logic [7:0] c);
    hst_t s;
    s = si;
    if (!(s.llen < 4 && c == node_char(s.llen[1:0]))) s.m_node = 1'b0;
    if (!(s.llen < 10 && c == js_char(s.llen[3:0]))) s.m_js = 1'b0;
    s.llen = s.llen + 1'b1;
    return s;
  endfunction

  // First character of a field
  function automatic hst_t skip_step(input hst_t si, input logic [7:0] c);
    hst_t s;
    logic [4:0] v;
    s = si;
    v = hfr_pkg::hex_val(c);
    if (!hfr_pkg::is_blank(c)) begin
      if (s.fld == 3'd1) begin
        s = lang_char(s, c);
        s.phase = PH_LANG;
      end else if (s.fld == 3'd5) begin
        if (v > 5'd15) begin
          s.phase = PH_FAIL;
        end else begin
          s.acc   = {60'd0, v[3:0]};
          s.phase = (c == 8'h30) ? PH_HEX0 : PH_HEX;
        end
      end else if (hfr_pkg::is_digit(c)) begin
        s.acc   = {60'd0, c[3:0]};
        s.phase = PH_NUM;
      end else begin
        s.phase = PH_FAIL;
      end
    end
    return s;
  endfunction

  // Checksum digit, saturating at 32 bits
  function automatic hst_t hex_step(input hst_t si, input logic [7:0] c,
                                    input logic [6:0] mid, input logic [18:0] mhex);
    hst_t s;
    logic [4:0]  v;
    logic [35:0] nv;
    s  = si;
    v  = hfr_pkg::hex_val(c);
    nv = {s.acc[31:0], v[3:0]};
    if (v > 5'd15) s = field_done(s, mid, mhex);
    else s.acc = (nv[35:32] != 4'd0) ? 64'h0000_0000_FFFF_FFFF : {28'd0, nv};
    return s;
  endfunction

  // One kept header character, with the re-examine pass
  function automatic hst_t hdr_char(input hst_t si, input logic [7:0] c,
                                    input logic [6:0] mid, input logic [18:0] mhex);
    hst_t s;
    logic redo;
    logic [67:0] m10;
    s    = si;
    redo = 1'b0;
    m10  = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {64'd0, c[3:0]};
    case (s.phase)
      PH_TAG: begin
        if (s.cnt < 3 && c == tag_char(s.cnt[1:0])) begin
          if (s.cnt == 2) s.phase = PH_SKIP;
        end else begin
          s.phase = PH_FAIL;
        end
      end
      PH_SKIP: s = skip_step(s, c);
      PH_NUM: begin
        if (hfr_pkg::is_digit(c)) begin
          s.acc = (m10[67:64] != 4'd0) ? '1 : m10[63:0];
        end else begin
          s    = field_done(s, mid, mhex);
          redo = 1'b1;
        end
      end
      PH_LANG: begin
        if (hfr_pkg::is_blank(c)) begin
          s = field_done(s, mid, mhex);
        end else if (s.llen >= hfr_pkg::LLEN_W'(hfr_pkg::LANG_MAX)) begin
          s    = field_done(s, mid, mhex);
          redo = 1'b1;
        end else begin
          s = lang_char(s, c);
        end
      end
      PH_HEX0: begin
        s.phase = PH_HEX;
        if (!(c == 8'h78 || c == 8'h58)) redo = 1'b1;
      end
      PH_HEX:  s = hex_step(s, c, mid, mhex);
      default: ;
    endcase
    if (redo) begin
      case (s.phase)
        PH_SKIP: s = skip_step(s, c);
        PH_HEX:  s = hex_step(s, c, mid, mhex);
        default: ;
      endcase
    end
    return s;
  endfunction

  // Next state and line-end summary
  always_comb begin
    hst_t s;
    logic fin;
    logic lend;
    logic [2:0] stat;
    s    = st_r;
    fin  = 1'b0;
    lend = 1'b0;
    stat = hfr_pkg::ST_OK;
    if (step) begin
      if (rx_byte == hfr_pkg::CH_LF) begin
        lend = 1'b1;
      end else if (rx_byte != hfr_pkg::CH_CR) begin
        if (rx_byte == hfr_pkg::CH_NUL) fin = 1'b1;
        else s = hdr_char(s, rx_byte, max_id, max_hex);
        s.cnt = s.cnt + 1'b1;
        if (s.cnt >= hfr_pkg::CNT_W'(hfr_pkg::HDR_LINE_MAX - 1)) lend = 1'b1;
      end
      if (fin || lend) begin
        if (s.phase == PH_NUM || s.phase == PH_LANG || s.phase == PH_HEX0 ||
            s.phase == PH_HEX) s = field_done(s, max_id, max_hex);
        if (s.phase != PH_DONE) s.phase = PH_FAIL;
      end
      if (lend) begin
        if (s.phase == PH_FAIL) stat = hfr_pkg::ST_BAD_HDR;
        else if (s.idl == 7'd0) stat = hfr_pkg::ST_BAD_ID;
        else if (s.szerr) stat = hfr_pkg::ST_TOO_BIG;
      end
    end
    info.line_end  = lend;
    info.status    = stat;
    info.id_len    = s.idl;
    info.code_hex  = s.chex;
    info.stdin_hex = s.shex;
    info.timeout   = s.tmo;
    info.checksum  = s.ck;
    info.node      = (s.m_node && s.llen == 4) || (s.m_js && s.llen == 10);
    // A closed frame or a rejected header starts over
    st_nxt = (restart || (lend && stat != hfr_pkg::ST_OK)) ? HST_RST : s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= HST_RST;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: rtl/hex_frame_receiver_fnv_check_core.sv
// Deframer for a byte-serial request link. Each frame is an ASCII header line
// "ZB1 id_len language timeout code_hex stdin_hex checksum" ended by
// LF (CR dropped, line cut after 511 kept characters), then a body of id bytes,
// code hex and stdin hex. Id bytes come out raw (kind 0), hex pairs come out
// decoded (kinds 1 and 2) and are provisional until the verdict (kind 3),
// which closes every frame with status, runtime select, timeout and sizes.
// The body is checked by a 32-bit FNV-1a hash against the header checksum.
// One byte is taken every clock cycle; a byte's result appears on the output
// register the cycle after it is taken, and input is held off only while that
// register is full and not being drained. Limits must be written through the
// cfg port only while the block is idle; the block does not enforce this.
module hex_frame_receiver_fnv_check_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [2:0]  out_frame_status,
  output logic        out_use_node_runtime,
  output logic [63:0] out_timeout_ms,
  output logic [6:0]  out_id_length,
  output logic [17:0] out_code_bytes,
  output logic [17:0] out_stdin_bytes,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [18:0] cfg_wdata
);

  logic [6:0]  max_id_r;
  logic [18:0] max_hex_r;
  logic [17:0] max_code_r, max_stdin_r;

  logic        body_r, body_nxt;
  logic [19:0] rem_r, rem_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic        nib_r, nib_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic        herr_r, herr_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        node_r, node_nxt;
  logic [63:0] tmo_r, tmo_nxt;
  logic [6:0]  idl_r, idl_nxt;
  logic [17:0] cb_r, cb_nxt, sb_r, sb_nxt;

  logic               acc;
  logic               verdict;
  hfr_pkg::hdr_info_t hinfo;

  assign in_ready = !ov_r || out_ready;
  assign acc      = in_valid && in_ready;

  hfr_hdr u_hdr (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (acc && !body_r),
    .rx_byte (in_rx_byte),
    .restart (verdict),
    .max_id  (max_id_r),
    .max_hex (max_hex_r),
    .info    (hinfo)
  );

  // Body byte handling and result selection
  always_comb begin
    logic [19:0] tail;
    logic [19:0] rem_d;
    logic [4:0]  v;
    logic        have;
    logic [7:0]  data;
    logic [1:0]  kind;
    logic [17:0] cb, sb;
    logic [2:0]  st;
    tail  = {1'b0, hinfo.code_hex} + {1'b0, hinfo.stdin_hex};
    v     = hfr_pkg::hex_val(in_rx_byte);
    have  = 1'b0;
    data  = 8'd0;
    kind  = hfr_pkg::KIND_ID;
    cb    = hinfo.code_hex[18:1];
    sb    = hinfo.stdin_hex[18:1];
    st    = hfr_pkg::ST_OK;
    rem_d = rem_r;

    body_nxt = body_r;
    rem_nxt  = rem_r;
    hash_nxt = hash_r;
    nib_nxt  = nib_r;
    hi_nxt   = hi_r;
    herr_nxt = herr_r;
    verdict  = 1'b0;

    ov_nxt   = ov_r && !out_ready;
    kind_nxt = kind_r;
    byte_nxt = byte_r;
    stat_nxt = stat_r;
    node_nxt = node_r;
    tmo_nxt  = tmo_r;
    idl_nxt  = idl_r;
    cb_nxt   = cb_r;
    sb_nxt   = sb_r;

    if (acc && body_r) begin
      hash_nxt = hfr_pkg::fnv_step(hash_r, in_rx_byte);
      if (rem_r > tail) begin
        data = in_rx_byte;
        have = 1'b1;
      end else begin
        kind = (rem_r > {1'b0, hinfo.stdin_hex}) ? hfr_pkg::KIND_CODE : hfr_pkg::KIND_STDIN;
        // Pair phase restarts at each section's first character
        if (rem_r == ((kind == hfr_pkg::KIND_CODE) ? tail : {1'b0, hinfo.stdin_hex}))
          nib_nxt = 1'b0;
        if (v > 5'd15) herr_nxt = 1'b1;
        if (!nib_nxt) begin
          hi_nxt  = v[3:0];
          nib_nxt = 1'b1;
        end else begin
          nib_nxt = 1'b0;
          if (!herr_nxt) begin
            data = {hi_r, v[3:0]};
            have = 1'b1;
          end
        end
      end
      if (rem_r != 20'd0) rem_d = rem_r - 20'd1;
      rem_nxt = rem_d;

      if (rem_d == 20'd0) begin
        // Verdict: checksum, then hex, then limits
        if (hash_nxt != hinfo.checksum) st = hfr_pkg::ST_CHECKSUM;
        else if (herr_nxt || hinfo.code_hex[0] || hinfo.stdin_hex[0])
          st = hfr_pkg::ST_BAD_HEX;
        else if (cb > max_code_r || sb > max_stdin_r) st = hfr_pkg::ST_LIMITS;
        verdict  = 1'b1;
        body_nxt = 1'b0;
        hash_nxt = hfr_pkg::FNV_BASIS;
        nib_nxt  = 1'b0;
        hi_nxt   = 4'd0;
        herr_nxt = 1'b0;
        ov_nxt   = 1'b1;
        kind_nxt = hfr_pkg::KIND_VERDICT;
        byte_nxt = have ? data : 8'd0;
        stat_nxt = st;
        node_nxt = hinfo.node;
        tmo_nxt  = hinfo.timeout;
        idl_nxt  = hinfo.id_len;
        cb_nxt   = cb;
        sb_nxt   = sb;
      end else if (have) begin
        ov_nxt   = 1'b1;
        kind_nxt = kind;
        byte_nxt = data;
        stat_nxt = hfr_pkg::ST_OK;
        node_nxt = 1'b0;
        tmo_nxt  = 64'd0;
        idl_nxt  = 7'd0;
        cb_nxt   = 18'd0;
        sb_nxt   = 18'd0;
      end
    end else if (hinfo.line_end) begin
      if (hinfo.status == hfr_pkg::ST_OK) begin
        // Good header: open the body
        body_nxt = 1'b1;
        rem_nxt  = {13'd0, hinfo.id_len} + tail;
        hash_nxt = hfr_pkg::FNV_BASIS;
        nib_nxt  = 1'b0;
        herr_nxt = 1'b0;
      end else begin
        ov_nxt   = 1'b1;
        kind_nxt = hfr_pkg::KIND_VERDICT;
        byte_nxt = 8'd0;
        stat_nxt = hinfo.status;
        node_nxt = 1'b0;
        tmo_nxt  = 64'd0;
        idl_nxt  = 7'd0;
        cb_nxt   = 18'd0;
        sb_nxt   = 18'd0;
      end
    end
  end

  // Control state, limits and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_r      <= 1'b0;
      rem_r       <= '0;
      hash_r      <= hfr_pkg::FNV_BASIS;
      nib_r       <= 1'b0;
      hi_r        <= '0;
      herr_r      <= 1'b0;
      ov_r        <= 1'b0;
      max_id_r    <= 7'd127;
      max_hex_r   <= 19'd262144;
      max_code_r  <= 18'd131072;
      max_stdin_r <= 18'd65536;
    end else begin
      body_r <= body_nxt;
      rem_r  <= rem_nxt;
      hash_r <= hash_nxt;
      nib_r  <= nib_nxt;
      hi_r   <= hi_nxt;
      herr_r <= herr_nxt;
      ov_r   <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          hfr_pkg::CFG_MAX_ID:    max_id_r    <= cfg_wdata[6:0];
          hfr_pkg::CFG_MAX_HEX:   max_hex_r   <= cfg_wdata;
          hfr_pkg::CFG_MAX_CODE:  max_code_r  <= cfg_wdata[17:0];
          hfr_pkg::CFG_MAX_STDIN: max_stdin_r <= cfg_wdata[17:0];
          default: ;
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    stat_r <= stat_nxt;
    node_r <= node_nxt;
    tmo_r  <= tmo_nxt;
    idl_r  <= idl_nxt;
    cb_r   <= cb_nxt;
    sb_r   <= sb_nxt;
  end

  assign out_valid            = ov_r;
  assign out_kind             = kind_r;
  assign out_byte             = byte_r;
  assign out_frame_status     = stat_r;
  assign out_use_node_runtime = node_r;
  assign out_timeout_ms       = tmo_r;
  assign out_id_length        = idl_r;
  assign out_code_bytes       = cb_r;
  assign out_stdin_bytes      = sb_r;

endmodule
